FILE: src/jpid_pkg.sv
// Package for the joint PID controller: shared widths, Q16.16 constants,
// item and configuration types, sequencer states and saturation helpers.
// No dependencies.
`default_nettype none

package jpid_pkg;

  localparam int DW     = 32;           // data field width
  localparam int SW     = 48;           // integrator width
  localparam int FRAC   = 16;           // fractional bits of Q16.16
  localparam int STEPW  = 16;           // time step and reciprocal width
  localparam int MW     = 32;           // shared multiplier operand width
  localparam int PW     = 2 * MW;       // multiplier product width
  localparam int ACC_W  = PW + FRAC;    // product plus upper partial shift room
  localparam int ADDR_W = 5;            // six registers at 4-byte stride
  localparam int PDATA_W = 32;

  // angle wrap: quotient by two pi from a reciprocal product, then fix-up subtracts
  localparam int WRAP_W     = 33;
  localparam logic [DW-1:0]     PI_Q      = 32'd205887;
  localparam logic [WRAP_W-1:0] TWO_PI_Q  = 33'd411775;
  // pi plus 5216 times two pi keeps the dividend non-negative
  localparam logic [WRAP_W:0]   WRAP_BIAS = 34'd2148024287;
  // floor(2^48 / TWO_PI_Q), the raw Q16.16 two pi; applied to the dividend's upper 17 bits
  localparam logic [MW-1:0]     RECIP_2PI = 32'd683564997;

  localparam logic [ACC_W-1:0] ROUND_Q = ACC_W'(1) << (FRAC - 1);

  typedef enum logic [2:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_CONTROL_MODE  = 3'd3,
    REG_TIME_STEP     = 3'd4,
    REG_INV_TIME_STEP = 3'd5
  } reg_idx_e;

  typedef enum logic {
    MODE_POSITION = 1'b0,
    MODE_VELOCITY = 1'b1
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_QMUL,
    ST_WMUL,
    ST_WFIN,
    ST_RATE,
    ST_RMUL,
    ST_RFIN,
    ST_DERR,
    ST_SMUL,
    ST_SFIN,
    ST_ESUM,
    ST_PMUL,
    ST_PFIN,
    ST_IHMUL,
    ST_ILMUL,
    ST_IFIN,
    ST_DMUL,
    ST_DFIN,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic signed [DW-1:0] gain_p;
    logic signed [DW-1:0] gain_i;
    logic signed [DW-1:0] gain_d;
    mode_e                control_mode;
    logic [STEPW-1:0]     time_step;
    logic [STEPW-1:0]     inv_time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] target;
    logic signed [DW-1:0] measured;
    logic signed [DW-1:0] measured_rate;
    logic signed [DW-1:0] target_rate;
    logic                 target_rate_given;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] torque;
    logic signed [DW-1:0] p_term;
    logic signed [DW-1:0] i_term;
    logic signed [DW-1:0] d_term;
  } out_item_t;

  localparam logic [DW-1:0] DW_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DW_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [SW-1:0] SW_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SW_MIN = {1'b1, {(SW-1){1'b0}}};

  // one guard bit down to DW
  function automatic logic [DW-1:0] sat_dw1(input logic [DW:0] v);
    logic [DW-1:0] r;
    if (v[DW] != v[DW-1]) begin
      r = v[DW] ? DW_MIN : DW_MAX;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // two guard bits down to DW
  function automatic logic [DW-1:0] sat_dw2(input logic [DW+1:0] v);
    logic [DW-1:0] r;
    if ((v[DW+1] != v[DW]) || (v[DW] != v[DW-1])) begin
      r = v[DW+1] ? DW_MIN : DW_MAX;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] sat_sw1(input logic [SW:0] v);
    logic [SW-1:0] r;
    if (v[SW] != v[SW-1]) begin
      r = v[SW] ? SW_MIN : SW_MAX;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] abs_dw(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  function automatic logic [SW-1:0] abs_sw(input logic [SW-1:0] v);
    return v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/jpid_in_if.sv
// Input channel of the joint PID controller: valid/ready plus one tick item.
// Depends on jpid_pkg.
`default_nettype none

interface jpid_in_if;
  import jpid_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/jpid_out_if.sv
// Result channel of the joint PID controller: valid/ready plus torque and terms.
// Depends on jpid_pkg.
`default_nettype none

interface jpid_out_if;
  import jpid_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/jpid_apb_regs.sv
// APB register file for the joint PID controller: gains, mode, time step.
// Depends on jpid_pkg.
`default_nettype none

module jpid_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jpid_pkg::ADDR_W-1:0] paddr,
  input  wire logic [jpid_pkg::PDATA_W-1:0] pwdata,
  output logic      [jpid_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output jpid_pkg::cfg_t                   cfg_o
);
  import jpid_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= '0;
      cfg_q.gain_i        <= '0;
      cfg_q.gain_d        <= '0;
      cfg_q.control_mode  <= MODE_POSITION;
      cfg_q.time_step     <= STEPW'(66);
      cfg_q.inv_time_step <= STEPW'(1000);
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:        cfg_q.gain_p        <= pwdata[DW-1:0];
        REG_GAIN_I:        cfg_q.gain_i        <= pwdata[DW-1:0];
        REG_GAIN_D:        cfg_q.gain_d        <= pwdata[DW-1:0];
        REG_CONTROL_MODE:  cfg_q.control_mode  <= mode_e'(pwdata[0]);
        REG_TIME_STEP:     cfg_q.time_step     <= pwdata[STEPW-1:0];
        REG_INV_TIME_STEP: cfg_q.inv_time_step <= pwdata[STEPW-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_GAIN_P:        prdata = cfg_q.gain_p;
      REG_GAIN_I:        prdata = cfg_q.gain_i;
      REG_GAIN_D:        prdata = cfg_q.gain_d;
      REG_CONTROL_MODE:  prdata = {{(PDATA_W-1){1'b0}}, cfg_q.control_mode};
      REG_TIME_STEP:     prdata = {{(PDATA_W-STEPW){1'b0}}, cfg_q.time_step};
      REG_INV_TIME_STEP: prdata = {{(PDATA_W-STEPW){1'b0}}, cfg_q.inv_time_step};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/joint_pid_controller_top.sv
// Joint PID controller top level: tick sequencer around one shared 32x32
// multiplier. Depends on jpid_pkg, jpid_in_if, jpid_out_if, jpid_apb_regs.
`default_nettype none

// One accepted tick yields one result (torque, P, I and D terms, Q16.16,
// saturated). A sequencer feeds a single 32x32 unsigned multiplier one
// product at a time (wrap quotient, multiply-back, goal rate, step error,
// P, the two halves of I, D), each registered and used in the state after:
// the quotient is multiplied back, the remainder fixed up, the goal rate
// clamped, step error, P and D rounded and clamped, the I halves combined,
// rounded and clamped. The goal rate is derived from the goal change when
// none is given; in position mode the angle wrap estimates the quotient by
// two pi with a reciprocal product, multiplies back and fixes up the
// remainder. The input is ready again in the cycle the result first shows
// valid. A finished result sits in the output register while the next
// tick is taken and processed; a tick whose result finds it full waits.

module joint_pid_controller_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jpid_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [jpid_pkg::PDATA_W-1:0] pwdata,
  output logic      [jpid_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  jpid_in_if.sink                           in_i,
  jpid_out_if.source                        out_o
);
  import jpid_pkg::*;

  cfg_t cfg;

  jpid_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  in_item_t          item_q;
  out_item_t         out_q;
  logic              out_valid_q;
  logic [DW-1:0]     e_q, diff_q, goal_q, ed_q, p_q, i_q, d_q, prev_q;
  logic [SW-1:0]     step_q, es_q;
  logic [WRAP_W-1:0] y_q;
  logic [PW-1:0]     prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic              neg_q;

  logic in_acc, load_out;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign load_out    = (state_q == ST_SUM) && (!out_valid_q || out_o.ready);

  // error, goal change, rate error and wrap dividend
  logic [DW-1:0]   err_sat, diff_sat, ed_sat;
  logic [WRAP_W:0] wrap_init;

  assign err_sat  = sat_dw1({item_q.target[DW-1], item_q.target}
                            - {item_q.measured[DW-1], item_q.measured});
  assign diff_sat = sat_dw1({item_q.target[DW-1], item_q.target}
                            - {prev_q[DW-1], prev_q});
  assign ed_sat   = sat_dw1({goal_q[DW-1], goal_q}
                            - {item_q.measured_rate[DW-1], item_q.measured_rate});
  assign wrap_init = {{(WRAP_W+1-DW){err_sat[DW-1]}}, err_sat} + WRAP_BIAS;

  // wrap remainder: the quotient estimate is low by at most two
  logic [WRAP_W-1:0] rem0, rem1, rem2;
  logic [DW-1:0]     wrap_e;

  assign rem0   = y_q - prod_q[WRAP_W-1:0];
  assign rem1   = (rem0 >= TWO_PI_Q) ? (rem0 - TWO_PI_Q) : rem0;
  assign rem2   = (rem1 >= TWO_PI_Q) ? (rem1 - TWO_PI_Q) : rem1;
  assign wrap_e = rem2[DW-1:0] - PI_Q;

  // shared multiplier operand select
  logic [MW-1:0] mul_a, mul_b;
  logic          mul_neg;
  logic [SW-1:0] es_mag;

  assign es_mag = abs_sw(es_q);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_q)
      ST_QMUL: begin
        mul_a = {{(MW-(WRAP_W-FRAC)){1'b0}}, y_q[WRAP_W-1:FRAC]};
        mul_b = RECIP_2PI;
      end
      ST_WMUL: begin
        mul_a = prod_q[PW-1:MW];
        mul_b = TWO_PI_Q[MW-1:0];
      end
      ST_RMUL: begin
        mul_a   = abs_dw(diff_q);
        mul_b   = {{(MW-STEPW){1'b0}}, cfg.inv_time_step};
        mul_neg = diff_q[DW-1];
      end
      ST_SMUL: begin
        mul_a   = abs_dw(e_q);
        mul_b   = {{(MW-STEPW){1'b0}}, cfg.time_step};
        mul_neg = e_q[DW-1];
      end
      ST_PMUL: begin
        mul_a   = abs_dw(cfg.gain_p);
        mul_b   = abs_dw(e_q);
        mul_neg = cfg.gain_p[DW-1] ^ e_q[DW-1];
      end
      ST_IHMUL: begin
        mul_a   = abs_dw(cfg.gain_i);
        mul_b   = {{(MW-(SW-DW)){1'b0}}, es_mag[SW-1:DW]};
        mul_neg = cfg.gain_i[DW-1] ^ es_q[SW-1];
      end
      ST_ILMUL: begin
        mul_a   = abs_dw(cfg.gain_i);
        mul_b   = es_mag[DW-1:0];
        mul_neg = cfg.gain_i[DW-1] ^ es_q[SW-1];
      end
      ST_DMUL: begin
        mul_a   = abs_dw(cfg.gain_d);
        mul_b   = abs_dw(ed_q);
        mul_neg = cfg.gain_d[DW-1] ^ ed_q[DW-1];
      end
      default: ;
    endcase
  end

  // round (bias preloaded into acc_q), shift, clamp, restore sign
  logic [ACC_W-1:0] fin_sum, fin_shift, fin_lim;
  logic [SW-1:0]    fin_mag, fin_res;
  logic             fin_sh, fin_w48;

  assign fin_sh    = (state_q != ST_RFIN);
  assign fin_w48   = (state_q == ST_SFIN);
  assign fin_sum   = acc_q + {{(ACC_W-PW){1'b0}}, prod_q};
  assign fin_shift = fin_sh ? (fin_sum >> FRAC) : fin_sum;
  assign fin_lim   = fin_w48
                   ? ((ACC_W'(1) << (SW-1)) - ACC_W'(1) + {{(ACC_W-1){1'b0}}, neg_q})
                   : ((ACC_W'(1) << (DW-1)) - ACC_W'(1) + {{(ACC_W-1){1'b0}}, neg_q});
  assign fin_mag   = (fin_shift > fin_lim) ? fin_lim[SW-1:0] : fin_shift[SW-1:0];
  assign fin_res   = neg_q ? (~fin_mag + SW'(1)) : fin_mag;

  logic [DW+1:0] tq_sum;
  assign tq_sum = {{2{p_q[DW-1]}}, p_q} + {{2{i_q[DW-1]}}, i_q}
                + {{2{d_q[DW-1]}}, d_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_ERR;
      ST_ERR:   state_d = (cfg.control_mode == MODE_POSITION) ? ST_QMUL : ST_RATE;
      ST_QMUL:  state_d = ST_WMUL;
      ST_WMUL:  state_d = ST_WFIN;
      ST_WFIN:  state_d = ST_RATE;
      ST_RATE:  state_d = item_q.target_rate_given ? ST_DERR : ST_RMUL;
      ST_RMUL:  state_d = ST_RFIN;
      ST_RFIN:  state_d = ST_DERR;
      ST_DERR:  state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_SFIN;
      ST_SFIN:  state_d = ST_ESUM;
      ST_ESUM:  state_d = ST_PMUL;
      ST_PMUL:  state_d = ST_PFIN;
      ST_PFIN:  state_d = ST_IHMUL;
      ST_IHMUL: state_d = ST_ILMUL;
      ST_ILMUL: state_d = ST_IFIN;
      ST_IFIN:  state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_DFIN;
      ST_DFIN:  state_d = ST_SUM;
      ST_SUM:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // tick state and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q        <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_ERR) prev_q <= item_q.target;
      if (state_q == ST_ESUM) begin
        es_q <= sat_sw1({es_q[SW-1], es_q} + {step_q[SW-1], step_q});
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: if (in_acc) item_q <= in_i.data;
      ST_ERR: begin
        e_q    <= err_sat;
        diff_q <= diff_sat;
        y_q    <= wrap_init[WRAP_W-1:0];
      end
      ST_WFIN: e_q <= wrap_e;
      ST_RATE: goal_q <= item_q.target_rate;
      ST_RMUL: begin
        neg_q <= mul_neg;
        acc_q <= '0;
      end
      ST_RFIN: goal_q <= fin_res[DW-1:0];
      ST_DERR: ed_q <= ed_sat;
      ST_SMUL, ST_PMUL, ST_IHMUL, ST_DMUL: begin
        neg_q <= mul_neg;
        acc_q <= ROUND_Q;
      end
      // upper partial of the integral product moves up by one word
      ST_ILMUL: acc_q <= {prod_q[ACC_W-DW-1:0], {DW{1'b0}}} | ROUND_Q;
      ST_SFIN:  step_q <= fin_res;
      ST_PFIN:  p_q <= fin_res[DW-1:0];
      ST_IFIN:  i_q <= fin_res[DW-1:0];
      ST_DFIN:  d_q <= fin_res[DW-1:0];
      ST_SUM: begin
        if (load_out) begin
          out_q.torque <= sat_dw2(tq_sum);
          out_q.p_term <= p_q;
          out_q.i_term <= i_q;
          out_q.d_term <= d_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/jpid_checker.sv
// Port-level checks for the joint PID controller, bound to the top level.
// Depends on jpid_pkg and joint_pid_controller_top.
`default_nettype none

module jpid_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire jpid_pkg::out_item_t out_data_i
);
  import jpid_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i & in_ready_i;

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

  // one tick in flight at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input taken while a tick is in progress");

  // a result never appears right after a transfer in
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_i))
    else $error("result raised one cycle after input transfer");

endmodule

bind joint_pid_controller_top jpid_checker u_jpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
